// ----- rtl/core/rtq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rtq_pkg;

    localparam int ENTRY_W = 16;
    localparam int QW_W    = 15;
    localparam int DIFF_W  = ENTRY_W + 1;
    localparam int DEN_W   = QW_W + 2;
    localparam int QUO_W   = 18;

    localparam logic [QW_W-1:0]    W_MAX   = 15'h7FFF;
    localparam logic [ENTRY_W-1:0] POS_SAT = 16'h7FFF;
    localparam logic [ENTRY_W-1:0] NEG_SAT = 16'h8000;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r01;
        logic signed [ENTRY_W-1:0] r02;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r12;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r22;
    } t_rot_in;

    typedef struct packed {
        logic        [QW_W-1:0]    quat_w;
        logic signed [ENTRY_W-1:0] quat_x;
        logic signed [ENTRY_W-1:0] quat_y;
        logic signed [ENTRY_W-1:0] quat_z;
        logic                      invalid;
    } t_quat_out;

endpackage

// ----- rtl/core/rotation_to_quaternion_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_to_quaternion_top
// Converts a Q2.14 rotation matrix into a unit quaternion by the trace method.
// ----------------------------------------------------------------------------
// Usage: each input item on i_in_data is one 3x3 rotation matrix, accepted
// when i_in_valid and o_in_ready are both high. Each item gives exactly one
// result item on o_out_data, taken when o_out_valid and i_out_ready are high.
// The scalar part w is computed by a digit-by-digit square root with one
// result bit per pipeline stage; x, y and z then go through three parallel
// restoring dividers with one quotient bit per stage.
// SQ_STEPS, the number of square root stages, is half the radicand width
// (23 stages at 14 fraction bits). One item can enter every cycle while
// the receiver does not stall.
// When one plus the trace is not positive the item reports invalid with all
// components zero. Vector components that do not fit saturate.
// Reset clears every valid bit, so the pipeline comes up empty. When the
// receiver stalls the whole pipeline holds in place and o_in_ready drops;
// no item is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_to_quaternion_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rtq_pkg::t_rot_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rtq_pkg::t_quat_out o_out_data
);
    import rtq_pkg::*;

    // Width of the signed trace sum, the radicand and the square root steps.
    localparam int S_W      = FRAC_BITS + 19;
    localparam int RAD_W    = S_W - 1 + FRAC_BITS;
    localparam int SQ_STEPS = (RAD_W + 1) / 2;
    localparam int VW       = 2 * SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 2;
    localparam int NUM_W    = FRAC_BITS + 18;
    localparam int CW       = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    localparam logic signed [S_W-1:0] S_ONE = S_W'(1) << FRAC_BITS;

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---------------- Input: trace sum and antisymmetric differences -------
    logic signed [S_W-1:0]    c_s;
    logic signed [DIFF_W-1:0] c_d [0:2];
    logic [VW-1:0]            c_rad;
    always_comb begin
        c_s = S_ONE + S_W'(i_in_data.r00) + S_W'(i_in_data.r11) + S_W'(i_in_data.r22);
        c_d[0] = DIFF_W'(i_in_data.r21) - DIFF_W'(i_in_data.r12);
        c_d[1] = DIFF_W'(i_in_data.r02) - DIFF_W'(i_in_data.r20);
        c_d[2] = DIFF_W'(i_in_data.r10) - DIFF_W'(i_in_data.r01);
        c_rad = '0;
        if (c_s > 0) begin
            c_rad = VW'(c_s[S_W-2:0]) << FRAC_BITS;
        end
    end

    // ---------------- Square root pipeline ---------------------------------
    logic                     r_sq_vld  [0:SQ_STEPS];
    logic [VW-1:0]            r_sq_rad  [0:SQ_STEPS];
    logic [REM_W-1:0]         r_sq_rem  [0:SQ_STEPS];
    logic [SQ_STEPS-1:0]      r_sq_root [0:SQ_STEPS];
    logic                     r_sq_inv  [0:SQ_STEPS];
    logic signed [DIFF_W-1:0] r_sq_d    [0:SQ_STEPS][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= i_in_valid;
        end
        if (en) begin
            r_sq_rad[0]  <= c_rad;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_inv[0]  <= !(c_s > 0);
            for (int i = 0; i < 3; i++) begin
                r_sq_d[0][i] <= c_d[i];
            end
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [REM_W:0]      cur;
        logic [REM_W:0]      trial;
        logic [REM_W-1:0]    n_rem;
        logic [SQ_STEPS-1:0] n_root;
        always_comb begin
            cur   = {r_sq_rem[k][REM_W-2:0], r_sq_rad[k][VW-1 -: 2]};
            trial = {1'b0, r_sq_root[k], 2'b01};
            if (cur >= trial) begin
                n_rem  = REM_W'(cur - trial);
                n_root = {r_sq_root[k][SQ_STEPS-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(cur);
                n_root = {r_sq_root[k][SQ_STEPS-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            if (en) begin
                r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
                r_sq_rem[k+1]  <= n_rem;
                r_sq_root[k+1] <= n_root;
                r_sq_inv[k+1]  <= r_sq_inv[k];
                for (int i = 0; i < 3; i++) begin
                    r_sq_d[k+1][i] <= r_sq_d[k][i];
                end
            end
        end
    end

    // ---------------- w, divisor and dividends -----------------------------
    logic [SQ_STEPS:0]   c_wfull;
    logic [QW_W-1:0]     c_w;
    logic [DEN_W-1:0]    c_den;
    logic                c_inv;
    logic [CW-1:0]       c_num [0:2];
    logic [DIFF_W-1:0]   c_mag [0:2];
    always_comb begin
        c_wfull = ((SQ_STEPS+1)'(r_sq_root[SQ_STEPS]) + 1'b1) >> 1;
        if (c_wfull > (SQ_STEPS+1)'(W_MAX)) begin
            c_w = W_MAX;
        end else begin
            c_w = QW_W'(c_wfull);
        end
        c_inv = r_sq_inv[SQ_STEPS] || (c_w == '0);
        c_den = {c_w, 2'b00};
        for (int i = 0; i < 3; i++) begin
            c_mag[i] = r_sq_d[SQ_STEPS][i][DIFF_W-1] ? DIFF_W'(-r_sq_d[SQ_STEPS][i])
                                                     : DIFF_W'(r_sq_d[SQ_STEPS][i]);
            c_num[i] = (CW'(c_mag[i]) << FRAC_BITS) + CW'({c_w, 1'b0});
        end
    end

    // ---------------- Divider pipeline (three lanes) -----------------------
    logic                r_dv_vld [0:QUO_W];
    logic [CW-1:0]       r_dv_rem [0:QUO_W][0:2];
    logic [QUO_W-1:0]    r_dv_q   [0:QUO_W][0:2];
    logic                r_dv_neg [0:QUO_W][0:2];
    logic [DEN_W-1:0]    r_dv_den [0:QUO_W];
    logic [QW_W-1:0]     r_dv_w   [0:QUO_W];
    logic                r_dv_inv [0:QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_sq_vld[SQ_STEPS];
        end
        if (en) begin
            r_dv_den[0] <= c_den;
            r_dv_w[0]   <= c_w;
            r_dv_inv[0] <= c_inv;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= c_num[i];
                r_dv_q[0][i]   <= '0;
                r_dv_neg[0][i] <= r_sq_d[SQ_STEPS][i][DIFF_W-1];
            end
        end
    end

    // A set top quotient bit means the result saturates, so an oversized
    // dividend need not be handled exactly there.
    for (genvar j = 0; j < QUO_W; j++) begin : g_dv
        logic [CW-1:0]    dsh;
        logic [CW-1:0]    n_rem [0:2];
        logic [QUO_W-1:0] n_q   [0:2];
        always_comb begin
            dsh = CW'(r_dv_den[j]) << (QUO_W - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (r_dv_rem[j][i] >= dsh) begin
                    n_rem[i] = r_dv_rem[j][i] - dsh;
                    n_q[i]   = {r_dv_q[j][i][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[i] = r_dv_rem[j][i];
                    n_q[i]   = {r_dv_q[j][i][QUO_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
            if (en) begin
                r_dv_den[j+1] <= r_dv_den[j];
                r_dv_w[j+1]   <= r_dv_w[j];
                r_dv_inv[j+1] <= r_dv_inv[j];
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j+1][i] <= n_rem[i];
                    r_dv_q[j+1][i]   <= n_q[i];
                    r_dv_neg[j+1][i] <= r_dv_neg[j][i];
                end
            end
        end
    end

    // ---------------- Sign, saturation and output register -----------------
    logic [ENTRY_W-1:0] c_vec [0:2];
    t_quat_out          c_out;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_neg[QUO_W][i]) begin
                if (r_dv_q[QUO_W][i] > QUO_W'(NEG_SAT)) begin
                    c_vec[i] = NEG_SAT;
                end else begin
                    c_vec[i] = ENTRY_W'(QUO_W'(0) - r_dv_q[QUO_W][i]);
                end
            end else begin
                if (r_dv_q[QUO_W][i] > QUO_W'(POS_SAT)) begin
                    c_vec[i] = POS_SAT;
                end else begin
                    c_vec[i] = ENTRY_W'(r_dv_q[QUO_W][i]);
                end
            end
        end
        c_out.invalid = r_dv_inv[QUO_W];
        if (r_dv_inv[QUO_W]) begin
            c_out.quat_w = '0;
            c_out.quat_x = '0;
            c_out.quat_y = '0;
            c_out.quat_z = '0;
        end else begin
            c_out.quat_w = r_dv_w[QUO_W];
            c_out.quat_x = c_vec[0];
            c_out.quat_y = c_vec[1];
            c_out.quat_z = c_vec[2];
        end
    end

    logic      r_out_vld;
    t_quat_out r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[QUO_W];
        end
        if (en) begin
            r_out <= c_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ---------------- Assertions -------------------------------------------
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.invalid |->
            o_out_data.quat_w == '0 && o_out_data.quat_x == '0 &&
            o_out_data.quat_y == '0 && o_out_data.quat_z == '0)
        else $error("invalid item carries nonzero components");

    a_w_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.invalid |-> o_out_data.quat_w != '0)
        else $error("valid quaternion with zero scalar part");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dv_vld[QUO_W]) && $stable(r_sq_vld[SQ_STEPS]))
        else $error("pipeline moved during a stall");

endmodule

// ----- dv/rotation_to_quaternion_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_to_quaternion_top_test
// Self-checking bench for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
// Matrices are queued by an initial block and sent by a clocked driver; a
// clocked monitor compares each quaternion with a prediction computed in the
// bench when the matrix was accepted. Both sides idle at random, and the
// receiver once holds off long enough for the pipeline to fill and stall.
// ----------------------------------------------------------------------------
module rotation_to_quaternion_top_test;
    import rtq_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = 44;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_rot_in   in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_quat_out out_data;

    t_rot_in   pending_mats[$];
    t_quat_out expected_quats[$];
    int        error_count = 0;
    bit        idle_free = 1'b0;     // a stretch with no idling on either side
    bit        hold_off = 1'b0;      // receiver hold-off in progress
    bit        stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    rotation_to_quaternion_top #(.FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    // Integer square root, bit by bit, on a 64-bit radicand.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Rounded, saturated quotient of an antisymmetric difference by 4w.
    function automatic logic [15:0] vector_part(longint d, longint unsigned den);
        longint unsigned mag, q;
        mag = (d < 0) ? -d : d;
        q = ((mag << FRAC) + (den >> 1)) / den;
        if (d < 0) return (q > 32768) ? NEG_SAT : 16'(-longint'(q));
        return (q > 32767) ? POS_SAT : 16'(q);
    endfunction

    function automatic t_quat_out quat_from_matrix(t_rot_in m);
        t_quat_out q;
        longint s;
        longint unsigned w;
        q = '0;
        q.invalid = 1'b1;
        s = (longint'(1) << FRAC) + m.r00 + m.r11 + m.r22;
        if (s <= 0) return q;
        w = (int_sqrt(longint'(s) << FRAC) + 1) >> 1;
        if (w > 32767) w = 32767;
        if (w == 0) return q;
        q.quat_w = 15'(w);
        q.quat_x = vector_part(longint'(m.r21) - m.r12, 4 * w);
        q.quat_y = vector_part(longint'(m.r02) - m.r20, 4 * w);
        q.quat_z = vector_part(longint'(m.r10) - m.r01, 4 * w);
        q.invalid = 1'b0;
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);                         // any pattern
            1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Small-angle rotations: near identity, big trace, small differences.
    function automatic t_rot_in near_identity();
        t_rot_in m;
        m.r00 = 16'(16384 - $urandom_range(0, 3000));
        m.r11 = 16'(16384 - $urandom_range(0, 3000));
        m.r22 = 16'(16384 - $urandom_range(0, 3000));
        m.r01 = 16'($signed($urandom_range(0, 8000)) - 4000);
        m.r02 = 16'($signed($urandom_range(0, 8000)) - 4000);
        m.r10 = 16'($signed($urandom_range(0, 8000)) - 4000);
        m.r12 = 16'($signed($urandom_range(0, 8000)) - 4000);
        m.r20 = 16'($signed($urandom_range(0, 8000)) - 4000);
        m.r21 = 16'($signed($urandom_range(0, 8000)) - 4000);
        return m;
    endfunction

    function automatic t_rot_in mat(int a00, int a01, int a02, int a10, int a11,
                                    int a12, int a20, int a21, int a22);
        t_rot_in m;
        m.r00 = 16'(a00); m.r01 = 16'(a01); m.r02 = 16'(a02);
        m.r10 = 16'(a10); m.r11 = 16'(a11); m.r12 = 16'(a12);
        m.r20 = 16'(a20); m.r21 = 16'(a21); m.r22 = 16'(a22);
        return m;
    endfunction

    initial begin
        t_rot_in m;
        // Directed: identity, a half-turn, a quarter-turn, the trace sum below
        // zero, at zero and just above it, tiny w so the vector parts saturate
        // both ways, and the extreme raw patterns.
        pending_mats.push_back(mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_mats.push_back(mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        pending_mats.push_back(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        pending_mats.push_back(mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        pending_mats.push_back(mat(-8192, 0, 0, 0, -8192, 0, 0, 0, 0));
        pending_mats.push_back(mat(-8192, 0, 0, 0, -8192, 0, 0, 0, 1));
        pending_mats.push_back(mat(-8192, 16384, -16384, -16384, -8192, 16384,
                                   16384, -16384, 1));
        pending_mats.push_back(mat(-8192, -16384, 16384, 16384, -8192, -16384,
                                   -16384, 16384, 1));
        pending_mats.push_back(mat(32767, 32767, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767));
        pending_mats.push_back(mat(-32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
        pending_mats.push_back(mat(0, 32767, -32768, -32768, 0, 32767,
                                   32767, -32768, 0));
        pending_mats.push_back(mat(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_mats.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_mats.push_back(mat(16384, 21, -7, 7, 16384, -3, 5, 3, 16384));
        for (int n = 0; n < 1950; n++) begin
            if ($urandom_range(0, 99) < 60) begin
                m = near_identity();
            end else begin
                m.r00 = rand_entry(); m.r01 = rand_entry(); m.r02 = rand_entry();
                m.r10 = rand_entry(); m.r11 = rand_entry(); m.r12 = rand_entry();
                m.r20 = rand_entry(); m.r21 = rand_entry(); m.r22 = rand_entry();
            end
            pending_mats.push_back(m);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: offers the next queued matrix, idling now and then.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                expected_quats.push_back(quat_from_matrix(in_data));
            end
            if (!in_valid || in_ready) begin
                if (pending_mats.size() != 0 &&
                        (idle_free || $urandom_range(0, 99) >= 22)) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_mats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                    if (pending_mats.size() == 0 && !(in_valid && !in_ready)) begin
                        stim_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Monitor: checks each accepted quaternion and sets the next ready.
    always @(posedge i_clk) begin
        t_quat_out want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_quats.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    want = expected_quats.pop_front();
                    if (out_data.quat_w !== want.quat_w)
                        report_mismatch("quat_w", out_data.quat_w, want.quat_w);
                    if (out_data.quat_x !== want.quat_x)
                        report_mismatch("quat_x", out_data.quat_x, want.quat_x);
                    if (out_data.quat_y !== want.quat_y)
                        report_mismatch("quat_y", out_data.quat_y, want.quat_y);
                    if (out_data.quat_z !== want.quat_z)
                        report_mismatch("quat_z", out_data.quat_z, want.quat_z);
                    if (out_data.invalid !== want.invalid)
                        report_mismatch("invalid", out_data.invalid, want.invalid);
                end
            end
            if (hold_off) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= idle_free || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // Phases of the run: one long receiver hold-off so the pipeline fills and
    // backs up into the input, then a stretch with no idling, then drain.
    initial begin
        int guard;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
        repeat (400) @(posedge i_clk);
        idle_free <= 1'b1;
        repeat (400) @(posedge i_clk);
        idle_free <= 1'b0;
        wait (stim_done);
        guard = 0;
        while (expected_quats.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && expected_quats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
